// ----- rtl/pdmc_pkg.sv -----
// Shared types, constants and the control program of the PID distance move controller.
// Depends on nothing; imported by the top level and by its checker.
package pdmc_pkg;

  // Request and result payloads
  typedef struct packed {
    logic               start_move;
    logic signed [23:0] left_position;
    logic signed [23:0] right_position;
    logic        [7:0]  elapsed_ms;
  } in_req_t;

  typedef struct packed {
    logic signed [7:0]  drive_percent;
    logic               move_done;
    logic signed [31:0] position_error;
  } out_res_t;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET = 3'd0,
    CFG_CIRC   = 3'd1,
    CFG_KP     = 3'd2,
    CFG_KI     = 3'd3,
    CFG_KD     = 3'd4,
    CFG_TOL    = 3'd5,
    CFG_SETTLE = 3'd6
  } cfg_reg_t;

  // Register reset values
  localparam logic signed [31:0] TARGET_RST = 32'sd0;
  localparam logic [23:0]        CIRC_RST   = 24'd823550;
  localparam logic [23:0]        KP_RST     = 24'd327680;
  localparam logic [23:0]        KI_RST     = 24'd5243;
  localparam logic [23:0]        KD_RST     = 24'd0;
  localparam logic [30:0]        TOL_RST    = 31'd65536;
  localparam logic [15:0]        SETTLE_RST = 16'd50;

  // Settle timer
  localparam int unsigned TIMER_W   = 17;
  localparam logic [TIMER_W-1:0] TIMER_MAX = '1;

  // Shared multiplier, unsigned 32 x 24
  localparam int unsigned MUL_A_W = 32;
  localparam int unsigned MUL_B_W = 24;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

  // Radix-16 digit divider: distance / 720 = (m >> 4) / 45,
  // error change / 5000 = (m >> 3) / 625
  localparam int unsigned DIGIT_W    = 4;
  localparam int unsigned DIV_NUM_W  = 44;
  localparam int unsigned DIV_STEPS  = DIV_NUM_W / DIGIT_W;
  localparam int unsigned DIV_CNT_W  = 4;
  localparam int unsigned DIV_REM_W  = 10;
  localparam int unsigned DIV_X_W    = DIV_REM_W + DIGIT_W;
  localparam int unsigned DIST_SHIFT = 4;
  localparam int unsigned DIST_DIV   = 45;
  localparam int unsigned DLT_SHIFT  = 3;
  localparam int unsigned DLT_DIV    = 625;

  // Datapath widths
  localparam int unsigned DLT_W  = 22;
  localparam int unsigned TMAG_W = 43;
  localparam int unsigned TERM_W = TMAG_W + 1;
  localparam int unsigned SUM_W  = TERM_W + 2;
  localparam logic [TMAG_W-1:0] TERM_CLAMP = TMAG_W'(64'd1 << 42);
  localparam int unsigned PCT_MAX = 100;

  // k times the selected divisor, for the digit compares
  function automatic logic [DIV_X_W-1:0] div_multiple(input logic by_dlt,
                                                      input int unsigned k);
    return by_dlt ? DIV_X_W'(k * DLT_DIV) : DIV_X_W'(k * DIST_DIV);
  endfunction

  // Control program
  localparam int unsigned UPC_W = 5;

  typedef enum logic [3:0] {
    U_DMUL,   // position sum times circumference
    U_DSET,   // load divider with distance product
    U_DIGIT,  // one radix-16 quotient digit
    U_ERR,    // error from distance, saturate
    U_INTEG,  // integral update, load divider with error change
    U_DELTA,  // derivative input from quotient, clear sum
    U_MHI,    // high word of term magnitude times gain
    U_MLO,    // low word of term magnitude times gain
    U_TERM,   // assemble term, add to sum
    U_FINAL   // percent, settle timer, result
  } uop_t;

  typedef enum logic [1:0] {
    T_ERR,
    T_INT,
    T_DLT
  } term_sel_t;

  typedef enum logic [1:0] {
    J_NEXT,   // fall through
    J_LOOP,   // repeat until last digit
    J_DONE,   // jump when the move is done
    J_END     // end of program
  } jmp_t;

  typedef struct packed {
    uop_t             op;
    term_sel_t        term;
    jmp_t             jmp;
    logic [UPC_W-1:0] target;
  } uword_t;

  localparam logic [UPC_W-1:0] UPC_DIG_DIST = 5'd2;
  localparam logic [UPC_W-1:0] UPC_DIG_DLT  = 5'd5;
  localparam logic [UPC_W-1:0] UPC_FINAL    = 5'd16;

  function automatic uword_t ucode(input logic [UPC_W-1:0] pc);
    uword_t w;
    w = '{op: U_FINAL, term: T_ERR, jmp: J_END, target: UPC_FINAL};
    case (pc)
      5'd0:  w = '{op: U_DMUL,  term: T_ERR, jmp: J_NEXT, target: '0};
      5'd1:  w = '{op: U_DSET,  term: T_ERR, jmp: J_NEXT, target: '0};
      5'd2:  w = '{op: U_DIGIT, term: T_ERR, jmp: J_LOOP, target: UPC_DIG_DIST};
      5'd3:  w = '{op: U_ERR,   term: T_ERR, jmp: J_DONE, target: UPC_FINAL};
      5'd4:  w = '{op: U_INTEG, term: T_ERR, jmp: J_NEXT, target: '0};
      5'd5:  w = '{op: U_DIGIT, term: T_ERR, jmp: J_LOOP, target: UPC_DIG_DLT};
      5'd6:  w = '{op: U_DELTA, term: T_ERR, jmp: J_NEXT, target: '0};
      5'd7:  w = '{op: U_MHI,   term: T_ERR, jmp: J_NEXT, target: '0};
      5'd8:  w = '{op: U_MLO,   term: T_ERR, jmp: J_NEXT, target: '0};
      5'd9:  w = '{op: U_TERM,  term: T_ERR, jmp: J_NEXT, target: '0};
      5'd10: w = '{op: U_MHI,   term: T_INT, jmp: J_NEXT, target: '0};
      5'd11: w = '{op: U_MLO,   term: T_INT, jmp: J_NEXT, target: '0};
      5'd12: w = '{op: U_TERM,  term: T_INT, jmp: J_NEXT, target: '0};
      5'd13: w = '{op: U_MHI,   term: T_DLT, jmp: J_NEXT, target: '0};
      5'd14: w = '{op: U_MLO,   term: T_DLT, jmp: J_NEXT, target: '0};
      5'd15: w = '{op: U_TERM,  term: T_DLT, jmp: J_NEXT, target: '0};
      5'd16: w = '{op: U_FINAL, term: T_ERR, jmp: J_END,  target: UPC_FINAL};
      default: ;
    endcase
    return w;
  endfunction

endpackage

// ----- rtl/pid_distance_move_controller.sv -----
// A request is taken only while idle; in_stall stays high until the control program
// has issued the sample's result, so a new sample waits until the last is through.
// The program makes two 11-digit passes through the shared radix-16 divider and
// seven products on the one 32x24 multiplier; a done move skips to the final step.
// Reset (rst_n low at a clock edge) restores register defaults, clears the move state
// and drops any sample in flight; the block takes a request in the next cycle.
module pid_distance_move_controller
  import pdmc_pkg::*;
#(
  parameter int unsigned INTEGRAL_BITS = 48
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_req_t               in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_res_t              out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned IB = INTEGRAL_BITS;
  localparam logic signed [IB-1:0] INT_MAX = {1'b0, {(IB-1){1'b1}}};
  localparam logic signed [IB-1:0] INT_MIN = {1'b1, {(IB-1){1'b0}}};

  typedef enum logic {ST_IDLE, ST_RUN} st_t;

  // Control state
  st_t                     state_r, state_nxt;
  logic [UPC_W-1:0]        pc_r, pc_nxt;
  logic                    out_valid_r, out_valid_nxt;
  out_res_t                out_data_r, out_data_nxt;

  // Configuration registers
  logic signed [31:0]      target_r, target_nxt;
  logic [23:0]             circ_r, circ_nxt;
  logic [23:0]             kp_r, kp_nxt;
  logic [23:0]             ki_r, ki_nxt;
  logic [23:0]             kd_r, kd_nxt;
  logic [30:0]             tol_r, tol_nxt;
  logic [15:0]             settle_r, settle_nxt;

  // Move state
  logic signed [IB-1:0]    integ_r, integ_nxt;
  logic signed [31:0]      prev_r, prev_nxt;
  logic [TIMER_W-1:0]      timer_r, timer_nxt;
  logic                    done_r, done_nxt;

  // Working registers
  in_req_t                 samp_r, samp_nxt;
  logic [MUL_P_W-1:0]      prod_r, prod_nxt;
  logic [MUL_P_W-1:0]      hprod_r, hprod_nxt;
  logic                    neg_r, neg_nxt;
  logic [DIV_NUM_W-1:0]    num_r, num_nxt;
  logic [DIV_REM_W-1:0]    rem_r, rem_nxt;
  logic [DIV_CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                    div_dlt_r, div_dlt_nxt;
  logic signed [31:0]      err_r, err_nxt;
  logic signed [DLT_W-1:0] delta_r, delta_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;

  // Combinational datapath
  uword_t                  uw;
  logic                    in_acc;
  logic                    fin_go;
  logic signed [24:0]      pos_sum;
  logic [24:0]             pos_mag;
  logic signed [63:0]      term_x;
  logic                    term_neg;
  logic [63:0]             term_mag;
  logic [MUL_B_W-1:0]      gain;
  logic [MUL_A_W-1:0]      mul_a;
  logic [MUL_B_W-1:0]      mul_b;
  logic [MUL_P_W-1:0]      mul_p;
  logic                    clamp_hi;
  logic [TMAG_W-1:0]       t_raw;
  logic [TMAG_W-1:0]       t_mag;
  logic signed [TERM_W-1:0] term_val;
  logic [DIV_X_W-1:0]      div_x;
  logic [DIV_X_W-1:0]      div_sub;
  logic [DIGIT_W-1:0]      div_q;
  logic signed [45:0]      quo_s;
  logic signed [45:0]      dist_s;
  logic signed [46:0]      err_wide;
  logic signed [31:0]      err_sat;
  logic signed [IB:0]      isum;
  logic signed [32:0]      diff;
  logic [32:0]             diff_mag;
  logic [SUM_W-1:0]        sum_mag;
  logic [SUM_W-17:0]       pct_q;
  logic [6:0]              pct_mag;
  logic signed [7:0]       pct;
  logic [31:0]             aerr;
  logic [TIMER_W:0]        timer_add;
  logic [TIMER_W-1:0]      timer_sat;
  logic [TIMER_W-1:0]      timer_new;
  logic                    done_new;

  assign uw        = ucode(pc_r);
  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign fin_go    = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Position sum and its magnitude
  always_comb begin
    pos_sum = 25'(samp_r.left_position) + 25'(samp_r.right_position);
    pos_mag = pos_sum[24] ? 25'(-pos_sum) : 25'(pos_sum);
  end

  // Select the term operand and its gain
  always_comb begin
    case (uw.term)
      T_ERR:   begin term_x = 64'(err_r);   gain = kp_r; end
      T_INT:   begin term_x = 64'(integ_r); gain = ki_r; end
      T_DLT:   begin term_x = 64'(delta_r); gain = kd_r; end
      default: begin term_x = '0;           gain = '0;   end
    endcase
    term_neg = term_x[63];
    term_mag = term_neg ? 64'(-term_x) : 64'(term_x);
  end

  // Shared multiplier
  always_comb begin
    case (uw.op)
      U_DMUL:  begin mul_a = MUL_A_W'(pos_mag); mul_b = circ_r; end
      U_MHI:   begin mul_a = term_mag[63:32];   mul_b = gain;   end
      U_MLO:   begin mul_a = term_mag[31:0];    mul_b = gain;   end
      default: begin mul_a = '0;                mul_b = '0;     end
    endcase
    mul_p = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
  end

  // Assemble a gain term: clamp magnitude at 2^42, rounded toward zero
  always_comb begin
    clamp_hi = |hprod_r[MUL_P_W-1:26];
    t_raw    = TMAG_W'({hprod_r[25:0], 16'b0}) + TMAG_W'(prod_r[MUL_P_W-1:16]);
    t_mag    = (clamp_hi || (t_raw > TERM_CLAMP)) ? TERM_CLAMP : t_raw;
    term_val = term_neg ? -$signed({1'b0, t_mag}) : $signed({1'b0, t_mag});
  end

  // One radix-16 quotient digit
  always_comb begin
    div_x   = {rem_r, num_r[DIV_NUM_W-1 -: DIGIT_W]};
    div_q   = '0;
    div_sub = '0;
    for (int unsigned k = 1; k < (1 << DIGIT_W); k++) begin
      if (div_x >= div_multiple(div_dlt_r, k)) begin
        div_q   = DIGIT_W'(k);
        div_sub = div_multiple(div_dlt_r, k);
      end
    end
  end

  // Error, integral and error change
  always_comb begin
    quo_s    = $signed({2'b0, num_r});
    dist_s   = neg_r ? -quo_s : quo_s;
    err_wide = 47'(target_r) - 47'(dist_s);
    if ((&err_wide[46:31]) || !(|err_wide[46:31])) begin
      err_sat = err_wide[31:0];
    end else begin
      err_sat = err_wide[46] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end
    isum     = (IB+1)'(integ_r) + (IB+1)'(err_r);
    diff     = 33'(err_r) - 33'(prev_r);
    diff_mag = diff[32] ? 33'(-diff) : 33'(diff);
  end

  // Percent and settle timer
  always_comb begin
    sum_mag   = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
    pct_q     = sum_mag[SUM_W-1:16];
    pct_mag   = (pct_q > (SUM_W-16)'(PCT_MAX)) ? 7'(PCT_MAX) : pct_q[6:0];
    pct       = sum_r[SUM_W-1] ? -$signed({1'b0, pct_mag}) : $signed({1'b0, pct_mag});
    aerr      = err_r[31] ? 32'(-err_r) : 32'(err_r);
    timer_add = (TIMER_W+1)'(timer_r) + (TIMER_W+1)'(samp_r.elapsed_ms);
    timer_sat = timer_add[TIMER_W] ? TIMER_MAX : timer_add[TIMER_W-1:0];
    timer_new = (aerr > {1'b0, tol_r}) ? '0 : timer_sat;
    done_new  = timer_new > TIMER_W'(settle_r);
  end

  // Sequencer and register updates
  always_comb begin
    state_nxt     = state_r;
    pc_nxt        = pc_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    target_nxt    = target_r;
    circ_nxt      = circ_r;
    kp_nxt        = kp_r;
    ki_nxt        = ki_r;
    kd_nxt        = kd_r;
    tol_nxt       = tol_r;
    settle_nxt    = settle_r;
    integ_nxt     = integ_r;
    prev_nxt      = prev_r;
    timer_nxt     = timer_r;
    done_nxt      = done_r;
    samp_nxt      = samp_r;
    prod_nxt      = prod_r;
    hprod_nxt     = hprod_r;
    neg_nxt       = neg_r;
    num_nxt       = num_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    div_dlt_nxt   = div_dlt_r;
    err_nxt       = err_r;
    delta_nxt     = delta_r;
    sum_nxt       = sum_r;

    // Drop a result once it is taken
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    // Register writes
    if (cfg_valid) begin
      case (cfg_index)
        CFG_TARGET: target_nxt = cfg_data;
        CFG_CIRC:   circ_nxt   = cfg_data[23:0];
        CFG_KP:     kp_nxt     = cfg_data[23:0];
        CFG_KI:     ki_nxt     = cfg_data[23:0];
        CFG_KD:     kd_nxt     = cfg_data[23:0];
        CFG_TOL:    tol_nxt    = cfg_data[30:0];
        CFG_SETTLE: settle_nxt = cfg_data[15:0];
        default: ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        // Take a request, clear move state on start
        if (in_acc) begin
          samp_nxt  = in_data;
          state_nxt = ST_RUN;
          pc_nxt    = '0;
          if (in_data.start_move) begin
            integ_nxt = '0;
            prev_nxt  = '0;
            timer_nxt = '0;
            done_nxt  = 1'b0;
          end
        end
      end
      ST_RUN: begin
        // Execute the current control word
        case (uw.op)
          U_DMUL: begin
            prod_nxt = mul_p;
            neg_nxt  = pos_sum[24];
          end
          U_DSET: begin
            num_nxt     = prod_r[DIST_SHIFT +: DIV_NUM_W];
            rem_nxt     = '0;
            cnt_nxt     = '0;
            div_dlt_nxt = 1'b0;
          end
          U_DIGIT: begin
            num_nxt = {num_r[DIV_NUM_W-DIGIT_W-1:0], div_q};
            rem_nxt = DIV_REM_W'(div_x - div_sub);
            cnt_nxt = cnt_r + 1'b1;
          end
          U_ERR: begin
            err_nxt = err_sat;
          end
          U_INTEG: begin
            if (isum[IB] != isum[IB-1]) begin
              integ_nxt = isum[IB] ? INT_MIN : INT_MAX;
            end else begin
              integ_nxt = isum[IB-1:0];
            end
            num_nxt     = DIV_NUM_W'(diff_mag[32:DLT_SHIFT]);
            neg_nxt     = diff[32];
            rem_nxt     = '0;
            cnt_nxt     = '0;
            div_dlt_nxt = 1'b1;
          end
          U_DELTA: begin
            delta_nxt = neg_r ? -$signed(num_r[DLT_W-1:0]) : $signed(num_r[DLT_W-1:0]);
            sum_nxt   = '0;
          end
          U_MHI: begin
            prod_nxt = mul_p;
          end
          U_MLO: begin
            hprod_nxt = prod_r;
            prod_nxt  = mul_p;
          end
          U_TERM: begin
            sum_nxt = sum_r + SUM_W'(term_val);
          end
          U_FINAL: begin
            if (fin_go) begin
              out_valid_nxt               = 1'b1;
              out_data_nxt.position_error = err_r;
              if (done_r) begin
                out_data_nxt.drive_percent = '0;
                out_data_nxt.move_done     = 1'b1;
              end else begin
                prev_nxt                   = err_r;
                timer_nxt                  = timer_new;
                done_nxt                   = done_new;
                out_data_nxt.drive_percent = done_new ? 8'sd0 : pct;
                out_data_nxt.move_done     = done_new;
              end
            end
          end
          default: ;
        endcase

        // Advance the step counter
        case (uw.jmp)
          J_NEXT: pc_nxt = pc_r + 1'b1;
          J_LOOP: pc_nxt = (cnt_r != DIV_CNT_W'(DIV_STEPS - 1)) ? uw.target : pc_r + 1'b1;
          J_DONE: pc_nxt = done_r ? uw.target : pc_r + 1'b1;
          J_END: begin
            if (fin_go) begin
              state_nxt = ST_IDLE;
            end
          end
          default: pc_nxt = pc_r + 1'b1;
        endcase
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    samp_r     <= samp_nxt;
    prod_r     <= prod_nxt;
    hprod_r    <= hprod_nxt;
    neg_r      <= neg_nxt;
    num_r      <= num_nxt;
    rem_r      <= rem_nxt;
    cnt_r      <= cnt_nxt;
    div_dlt_r  <= div_dlt_nxt;
    err_r      <= err_nxt;
    delta_r    <= delta_nxt;
    sum_r      <= sum_nxt;
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pc_r        <= '0;
      out_valid_r <= 1'b0;
      target_r    <= TARGET_RST;
      circ_r      <= CIRC_RST;
      kp_r        <= KP_RST;
      ki_r        <= KI_RST;
      kd_r        <= KD_RST;
      tol_r       <= TOL_RST;
      settle_r    <= SETTLE_RST;
      integ_r     <= '0;
      prev_r      <= '0;
      timer_r     <= '0;
      done_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
      target_r    <= target_nxt;
      circ_r      <= circ_nxt;
      kp_r        <= kp_nxt;
      ki_r        <= ki_nxt;
      kd_r        <= kd_nxt;
      tol_r       <= tol_nxt;
      settle_r    <= settle_nxt;
      integ_r     <= integ_nxt;
      prev_r      <= prev_nxt;
      timer_r     <= timer_nxt;
      done_r      <= done_nxt;
    end
  end

endmodule

// ----- rtl/pdmc_chk.sv -----
// Port-level checker for the PID distance move controller, bound to the top level.
// Depends on pdmc_pkg for the result payload type.
module pdmc_chk
  import pdmc_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_stall,
  input logic     out_valid,
  input logic     out_stall,
  input out_res_t out_data
);

  logic       in_acc;
  logic       out_acc;
  logic [1:0] pend_r, pend_nxt;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  // Track requests taken whose result is not yet delivered
  always_comb begin
    pend_nxt = pend_r + {1'b0, in_acc} - {1'b0, out_acc};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  // Every result answers a request
  a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc |-> pend_r != 2'd0)
    else $error("result without a pending request");

  // One sample in work plus one waiting result at most
  a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r == 2'd2 |-> in_stall)
    else $error("request taken with two samples outstanding");

  // A finished move drives zero
  a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.move_done |-> out_data.drive_percent == 8'sd0)
    else $error("nonzero drive after move done");

  // Drive stays within the percent range
  a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.drive_percent <= 8'sd100) && (out_data.drive_percent >= -8'sd100))
    else $error("drive percent out of range");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule

bind pid_distance_move_controller pdmc_chk u_pdmc_chk (.*);
